// ===== hdl/kmer_minimizer_extractor_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef KMER_MINIMIZER_EXTRACTOR_DEFINES_SVH
`define KMER_MINIMIZER_EXTRACTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KME_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("kme assertion failed");
`define KME_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("kme assertion failed");
`else
`define KME_ASSERT_SAME(label, clock, reset, ante, cons)
`define KME_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

// ===== hdl/kme_pkg.sv =====
`default_nettype none

package kme_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MAX_KMER   = 30;
  localparam int POS_BITS   = 32;
  localparam int HASH_W     = 60;
  localparam int KLEN_W     = 5;
  localparam int WLEN_W     = 7;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd1;

  localparam logic [KLEN_W-1:0] KMER_LEN_RESET   = 5'd15;
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 7'd10;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_N = 8'h4E;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_T = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_G = 2'd3;
  localparam logic [1:0] CODE_N = 2'd0;

  localparam logic RESULT_MIN = 1'b0;
  localparam logic RESULT_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ERR,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic issue;
    logic load_min;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic short_seq;
    logic scan_last;
    logic need_emit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/kme_ctrl.sv =====
`default_nettype none

module kme_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire kme_pkg::status_t status,
  output kme_pkg::cmd_t         cmd
);

  kme_pkg::state_t state;
  kme_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kme_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kme_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = kme_pkg::ST_PREP;
        end
      end
      kme_pkg::ST_PREP: begin
        if (status.invalid) begin
          state_next = kme_pkg::ST_ERR;
        end else if (status.short_seq) begin
          state_next = kme_pkg::ST_IDLE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = kme_pkg::ST_SCAN;
        end
      end
      kme_pkg::ST_ERR: begin
        if (status.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = kme_pkg::ST_IDLE;
        end
      end
      kme_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = kme_pkg::ST_DRAIN;
        end
      end
      kme_pkg::ST_DRAIN: begin
        // last read word is compared in this cycle
        state_next = kme_pkg::ST_DECIDE;
      end
      kme_pkg::ST_DECIDE: begin
        if (!status.need_emit) begin
          state_next = kme_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.load_min = 1'b1;
          state_next   = kme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kme_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/kme_datapath.sv =====
`default_nettype none

module kme_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [kme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kme_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [7:0]                        base_char,
  input  wire logic                              seq_start,
  input  wire kme_pkg::cmd_t                     cmd,
  output kme_pkg::status_t                       status,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   result_kind,
  output logic [kme_pkg::HASH_W-1:0]             kmer_hash,
  output logic [kme_pkg::POS_BITS-1:0]           min_pos
);

  localparam int PB = kme_pkg::POS_BITS;
  localparam int HW = kme_pkg::HASH_W;
  localparam int KW = kme_pkg::KLEN_W;
  localparam int WW = kme_pkg::WLEN_W;
  localparam int AW = kme_pkg::WIN_AW;

  logic [KW-1:0] kmer_len;
  logic [WW-1:0] window_len;
  logic [KW-1:0] k_eff;
  logic [WW-1:0] w_eff;

  logic [HW-1:0] rolling_kmer;
  logic [PB-1:0] base_count;
  logic [PB-1:0] last_min_pos;
  logic          last_min_valid;
  logic          invalid_q;

  logic [HW-1:0] window_mem [kme_pkg::MAX_WINDOW];
  logic [HW-1:0] rd_data;

  logic [PB-1:0] rd_pos;
  logic [WW-1:0] rd_left;
  logic          cmp_valid;
  logic          cmp_first;
  logic [PB-1:0] cmp_pos;
  logic [HW-1:0] best_hash;
  logic [PB-1:0] best_pos;

  logic          code_ok;
  logic [1:0]    code;
  logic [HW-1:0] kmask;
  logic [HW-1:0] rolling_base;
  logic [PB-1:0] count_base;
  logic [PB-1:0] k_wide;
  logic [PB-1:0] pos;
  logic [PB:0]   nk;
  logic [WW-1:0] n;
  logic [PB-1:0] scan_start;
  logic          out_free;

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = KW'(1);
    end else if (kmer_len > KW'(kme_pkg::MAX_KMER)) begin
      k_eff = KW'(kme_pkg::MAX_KMER);
    end else begin
      k_eff = kmer_len;
    end
    if (window_len == '0) begin
      w_eff = WW'(1);
    end else if (window_len > WW'(kme_pkg::MAX_WINDOW)) begin
      w_eff = WW'(kme_pkg::MAX_WINDOW);
    end else begin
      w_eff = window_len;
    end
  end

  always_comb begin
    code_ok = 1'b1;
    code    = kme_pkg::CODE_A;
    case (base_char)
      kme_pkg::CHAR_A: code = kme_pkg::CODE_A;
      kme_pkg::CHAR_T: code = kme_pkg::CODE_T;
      kme_pkg::CHAR_C: code = kme_pkg::CODE_C;
      kme_pkg::CHAR_G: code = kme_pkg::CODE_G;
      kme_pkg::CHAR_N: code = kme_pkg::CODE_N;
      default:         code_ok = 1'b0;
    endcase
  end

  // a new sequence starts from cleared state, also for a bad base
  assign rolling_base = seq_start ? '0 : rolling_kmer;
  assign count_base   = seq_start ? '0 : base_count;
  assign kmask        = ~({HW{1'b1}} << {k_eff, 1'b0});

  assign k_wide     = PB'(k_eff);
  assign pos        = base_count - k_wide;
  assign nk         = {1'b0, pos} + (PB+1)'(1);
  assign n          = (nk < (PB+1)'(w_eff)) ? nk[WW-1:0] : w_eff;
  assign scan_start = pos - PB'(n) + PB'(1);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    status           = '0;
    status.invalid   = invalid_q;
    status.short_seq = base_count < k_wide;
    status.scan_last = rd_left == WW'(1);
    status.need_emit = !last_min_valid || (best_pos != last_min_pos);
    status.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len   <= kme_pkg::KMER_LEN_RESET;
      window_len <= kme_pkg::WINDOW_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kme_pkg::REG_KMER_LEN:   kmer_len <= cfg_data[KW-1:0];
        kme_pkg::REG_WINDOW_LEN: window_len <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_kmer   <= '0;
      base_count     <= '0;
      last_min_pos   <= '0;
      last_min_valid <= 1'b0;
      invalid_q      <= 1'b0;
      cmp_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue;
      if (cmd.accept) begin
        invalid_q <= !code_ok;
        if (seq_start) begin
          last_min_pos   <= '0;
          last_min_valid <= 1'b0;
        end
        if (code_ok) begin
          rolling_kmer <= ((rolling_base << 2) & kmask) | HW'(code);
          base_count   <= count_base + PB'(1);
        end else begin
          rolling_kmer <= rolling_base;
          base_count   <= count_base;
        end
      end
      if (cmd.load_min) begin
        last_min_valid <= 1'b1;
        last_min_pos   <= best_pos;
      end
      if (cmd.load_min || cmd.load_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      window_mem[pos[AW-1:0]] <= rolling_kmer;
    end
    if (cmd.issue) begin
      rd_data <= window_mem[rd_pos[AW-1:0]];
    end
  end

  // read one window entry a cycle, compare it the cycle after
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rd_pos    <= scan_start;
      rd_left   <= n;
      cmp_first <= 1'b1;
    end else if (cmd.issue) begin
      rd_pos  <= rd_pos + PB'(1);
      rd_left <= rd_left - WW'(1);
      cmp_pos <= rd_pos;
    end
    if (cmp_valid) begin
      cmp_first <= 1'b0;
      // strict compare keeps the earliest on a tie
      if (cmp_first || (rd_data < best_hash)) begin
        best_hash <= rd_data;
        best_pos  <= cmp_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_min) begin
      result_kind <= kme_pkg::RESULT_MIN;
      kmer_hash   <= best_hash;
      min_pos     <= best_pos;
    end else if (cmd.load_err) begin
      result_kind <= kme_pkg::RESULT_ERR;
      kmer_hash   <= '0;
      min_pos     <= base_count;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kmer_minimizer_extractor.sv =====
// Rolling k-mer window minimizer.
// Input channel (in_valid/in_ready) carries one ASCII base per word plus
// seq_start, which clears the running k-mer, base count and last minimiser
// before that base is used. Output channel (out_valid/out_ready) carries at
// most one word per input word: result_kind 0 with the window minimum's
// hash and start position when its position moves, or result_kind 1 with
// hash 0 and the base index when the character is not A, T, C, G or N.
// kmer_len and window_len are written through cfg_write/cfg_index/cfg_data
// while the block is idle, a rule on the user that the block does not
// enforce; out-of-range values are clamped. Each input word passes IDLE and
// PREP; under kmer_len bases sends it back to IDLE, a bad character on to ERR;
// else SCAN reads n entries (window_len, fewer at the head of a sequence)
// of the single-port window memory, one entry a cycle, then DRAIN and DECIDE.
// Reset restores kmer_len 15 and window_len 10 and clears all running
// state; the window memory needs no clearing pass. A stalled receiver holds
// the result in the output register; the next word is still taken and
// worked on, and waits only when it has a result of its own to hand over.
`default_nettype none
`include "kmer_minimizer_extractor_defines.svh"

module kmer_minimizer_extractor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [kme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kme_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    base_char,
  input  wire logic                          seq_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               result_kind,
  output logic [kme_pkg::HASH_W-1:0]         kmer_hash,
  output logic [kme_pkg::POS_BITS-1:0]       min_pos
);

  kme_pkg::cmd_t    cmd;
  kme_pkg::status_t status;

  kme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kme_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .base_char   (base_char),
    .seq_start   (seq_start),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .kmer_hash   (kmer_hash),
    .min_pos     (min_pos)
  );

  `KME_ASSERT_NEXT(busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `KME_ASSERT_SAME(err_hash_zero, clk, rst, out_valid && result_kind, kmer_hash == '0)
  `KME_ASSERT_SAME(result_from_work, clk, rst, $rose(out_valid), !$past(in_ready))

endmodule

`default_nettype wire

// ===== test/kme_checker.sv =====
`timescale 1ns / 100ps

module kme_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kme_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    base_char,
  input  logic                          seq_start,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          result_kind,
  input  logic [kme_pkg::HASH_W-1:0]    kmer_hash,
  input  logic [kme_pkg::POS_BITS-1:0]  min_pos,
  output int                            pending,
  output int                            errors
);

  typedef struct packed {
    logic                         kind;
    logic [kme_pkg::HASH_W-1:0]   hash;
    logic [kme_pkg::POS_BITS-1:0] pos;
  } minimizer_t;

  minimizer_t                   pending_minimizers[$];
  int                           mismatch_cnt = 0;

  logic [kme_pkg::KLEN_W-1:0]   kmer_len_reg;
  logic [kme_pkg::WLEN_W-1:0]   window_len_reg;
  logic [kme_pkg::HASH_W-1:0]   kmer_value;
  logic [kme_pkg::HASH_W-1:0]   window_mem [kme_pkg::MAX_WINDOW];
  logic [kme_pkg::POS_BITS-1:0] base_count;
  logic [kme_pkg::POS_BITS-1:0] last_pos;
  logic                         last_valid;

  function automatic int base_code(input logic [7:0] ch);
    case (ch)
      kme_pkg::CHAR_A: return int'(kme_pkg::CODE_A);
      kme_pkg::CHAR_T: return int'(kme_pkg::CODE_T);
      kme_pkg::CHAR_C: return int'(kme_pkg::CODE_C);
      kme_pkg::CHAR_G: return int'(kme_pkg::CODE_G);
      kme_pkg::CHAR_N: return int'(kme_pkg::CODE_N);
      default: return -1;
    endcase
  endfunction

  task automatic predict_minimizer(input logic [7:0] ch, input logic ss);
    int                           code;
    int                           k;
    int                           w;
    int                           n;
    logic [kme_pkg::HASH_W-1:0]   kmask;
    logic [kme_pkg::POS_BITS-1:0] kmer_start;
    logic [kme_pkg::POS_BITS-1:0] scan_from;
    logic [kme_pkg::POS_BITS-1:0] p;
    logic [kme_pkg::POS_BITS-1:0] best_pos;
    logic [kme_pkg::HASH_W-1:0]   best_hash;
    minimizer_t                   word;

    k = (kmer_len_reg == 0) ? 1 :
        (kmer_len_reg > kme_pkg::MAX_KMER) ? kme_pkg::MAX_KMER : int'(kmer_len_reg);
    w = (window_len_reg == 0) ? 1 :
        (window_len_reg > kme_pkg::MAX_WINDOW) ? kme_pkg::MAX_WINDOW : int'(window_len_reg);

    // clear before the base is looked at, bad character or not
    if (ss) begin
      kmer_value = '0;
      base_count = '0;
      last_pos = '0;
      last_valid = 1'b0;
    end

    code = base_code(ch);
    if (code < 0) begin
      word.kind = kme_pkg::RESULT_ERR;
      word.hash = '0;
      word.pos = base_count;
      pending_minimizers = {pending_minimizers, word};
      return;
    end

    kmask = '1;
    kmask = kmask >> (kme_pkg::HASH_W - 2 * k);
    kmer_value = ((kmer_value << 2) & kmask) | kme_pkg::HASH_W'(code);
    base_count = base_count + 1'b1;
    if (base_count < k) return;

    kmer_start = base_count - k;
    window_mem[kmer_start % kme_pkg::MAX_WINDOW] = kmer_value;

    n = (kmer_start + 1 < w) ? int'(kmer_start) + 1 : w;
    scan_from = kmer_start - (n - 1);
    best_pos = scan_from;
    best_hash = window_mem[scan_from % kme_pkg::MAX_WINDOW];
    // strict compare keeps the earliest position on a tie
    for (int j = 1; j < n; j++) begin
      p = scan_from + j;
      if (window_mem[p % kme_pkg::MAX_WINDOW] < best_hash) begin
        best_hash = window_mem[p % kme_pkg::MAX_WINDOW];
        best_pos = p;
      end
    end

    if (last_valid && best_pos == last_pos) return;
    last_valid = 1'b1;
    last_pos = best_pos;
    word.kind = kme_pkg::RESULT_MIN;
    word.hash = best_hash;
    word.pos = best_pos;
    pending_minimizers = {pending_minimizers, word};
  endtask

  always @(posedge clk) begin
    minimizer_t want;
    if (rst) begin
      pending_minimizers.delete();
      kmer_len_reg = kme_pkg::KMER_LEN_RESET;
      window_len_reg = kme_pkg::WINDOW_LEN_RESET;
      kmer_value = '0;
      base_count = '0;
      last_pos = '0;
      last_valid = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_minimizers.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d hash %h pos %0d",
                   $time, result_kind, kmer_hash, min_pos);
          mismatch_cnt++;
        end else begin
          want = pending_minimizers.pop_front();
          if (result_kind !== want.kind) begin
            $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, result_kind);
            mismatch_cnt++;
          end
          if (kmer_hash !== want.hash) begin
            $display("%0t: kmer_hash expected %h, got %h", $time, want.hash, kmer_hash);
            mismatch_cnt++;
          end
          if (min_pos !== want.pos) begin
            $display("%0t: min_pos expected %0d, got %0d", $time, want.pos, min_pos);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) predict_minimizer(base_char, seq_start);
      if (cfg_write) begin
        if (cfg_index == kme_pkg::REG_KMER_LEN) begin
          kmer_len_reg = cfg_data[kme_pkg::KLEN_W-1:0];
        end else if (cfg_index == kme_pkg::REG_WINDOW_LEN) begin
          window_len_reg = cfg_data[kme_pkg::WLEN_W-1:0];
        end
      end
    end
    pending <= pending_minimizers.size();
    errors <= mismatch_cnt;
  end

endmodule

// ===== test/tb_kmer_minimizer_extractor.sv =====
`timescale 1ns / 100ps

module tb_kmer_minimizer_extractor;

  localparam int MODE_NONE = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  localparam int ALPHA_ALL  = 0;
  localparam int ALPHA_LOW  = 1;
  localparam int ALPHA_HIGH = 2;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [kme_pkg::CFG_IDX_W-1:0] cfg_index = kme_pkg::REG_KMER_LEN;
  logic [kme_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    base_char = '0;
  logic                          seq_start = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          result_kind;
  logic [kme_pkg::HASH_W-1:0]    kmer_hash;
  logic [kme_pkg::POS_BITS-1:0]  min_pos;

  int awaiting;
  int failures;
  int idle_pct = 0;
  int stall_pct = 0;

  kmer_minimizer_extractor u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .base_char  (base_char),
    .seq_start  (seq_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .kmer_hash  (kmer_hash),
    .min_pos    (min_pos)
  );

  kme_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .base_char  (base_char),
    .seq_start  (seq_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .kmer_hash  (kmer_hash),
    .min_pos    (min_pos),
    .pending    (awaiting),
    .errors     (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [7:0] ch, input logic ss);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base_char <= ch;
    seq_start <= ss;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every minimizer is out, then let a silent word finish
  task automatic drain_minimizers;
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_lengths(input logic [kme_pkg::CFG_W-1:0] kmer_val,
                               input logic [kme_pkg::CFG_W-1:0] window_val);
    cfg_write <= 1'b1;
    cfg_index <= kme_pkg::REG_KMER_LEN;
    cfg_data <= kmer_val;
    @(posedge clk);
    cfg_index <= kme_pkg::REG_WINDOW_LEN;
    cfg_data <= window_val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_base(input int alphabet);
    int r;
    r = int'($urandom_range(4));
    case (alphabet)
      ALPHA_LOW:  return (r == 0) ? kme_pkg::CHAR_T : (r < 3) ? kme_pkg::CHAR_A : kme_pkg::CHAR_N;
      ALPHA_HIGH: return (r < 3) ? kme_pkg::CHAR_G : kme_pkg::CHAR_C;
      default: begin
        case (r)
          0: return kme_pkg::CHAR_A;
          1: return kme_pkg::CHAR_T;
          2: return kme_pkg::CHAR_C;
          3: return kme_pkg::CHAR_G;
          default: return kme_pkg::CHAR_N;
        endcase
      end
    endcase
  endfunction

  task automatic stream_sequences(input int count, input int mode);
    logic [7:0] ch;
    logic       ss;
    int         alphabet;
    idle_pct = (mode == MODE_SEND) ? 46 : (mode == MODE_BOTH) ? 28 : 0;
    stall_pct = (mode == MODE_RECV) ? 46 : (mode == MODE_BOTH) ? 28 : 0;
    alphabet = ALPHA_ALL;
    for (int i = 0; i < count; i++) begin
      // a new sequence always opens after a register change
      ss = (i == 0) || ($urandom_range(99) < 2);
      if (ss) alphabet = int'($urandom_range(2));
      if ($urandom_range(99) < 5) ch = 8'($urandom_range(255));
      else ch = pick_base(alphabet);
      send_word(ch, ss);
    end
  endtask

  initial begin
    logic [kme_pkg::CFG_W-1:0] kmer_val;
    logic [kme_pkg::CFG_W-1:0] window_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset lengths: first minimizer lands on position 0
    send_word("Z", 1'b1);
    repeat (15) send_word(kme_pkg::CHAR_G, 1'b0);
    send_word("a", 1'b0);
    send_word(kme_pkg::CHAR_A, 1'b0);
    send_word(kme_pkg::CHAR_T, 1'b0);
    send_word(kme_pkg::CHAR_C, 1'b0);
    send_word(kme_pkg::CHAR_N, 1'b0);
    send_word(kme_pkg::CHAR_N, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(kme_pkg::CHAR_G, 1'b1);
    send_word(kme_pkg::CHAR_C, 1'b0);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin kmer_val = 7'd0;  window_val = 7'd0;   end
        1: begin kmer_val = 7'd31; window_val = 7'd127; end
        2: begin kmer_val = 7'd1;  window_val = 7'd64;  end
        3: begin kmer_val = 7'd30; window_val = 7'd1;   end
        default: begin
          kmer_val = $urandom_range(1) ? 7'($urandom_range(8)) : 7'($urandom_range(127));
          window_val = 7'($urandom_range(127));
        end
      endcase
      drain_minimizers();
      write_lengths(kmer_val, window_val);
      stream_sequences(82, phase % 4);
    end

    drain_minimizers();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
